// ===== design/photon_hit_merge_table_defines.svh =====
// Assertion macros shared by the hit merge table RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef PHOTON_HIT_MERGE_TABLE_DEFINES_SVH
`define PHOTON_HIT_MERGE_TABLE_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define PHMT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an overlapping implication outside reset.
`define PHMT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a next-cycle implication outside reset.
`define PHMT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/phmt_pkg.sv =====
// Types, constants and codes of the photon hit merge table.
// No dependencies; used by the interfaces, the merge unit and the top level.
`timescale 1ns / 1ps
package phmt_pkg;

    localparam int CAPACITY  = 128;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    localparam logic [7:0]  LIMIT_RESET  = 8'd100;
    localparam logic [15:0] WINDOW_RESET = 16'd100;

    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b1;

    typedef enum logic [1:0] {
        FN_DETECT = 2'd0,
        FN_READ   = 2'd1,
        FN_COUNT  = 2'd2,
        FN_CLEAR  = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        ST_APPENDED  = 4'd0,
        ST_INSERTED  = 4'd1,
        ST_MERGED_E  = 4'd2,
        ST_MERGED_L  = 4'd3,
        ST_DROPPED   = 4'd4,
        ST_READ      = 4'd5,
        ST_BAD_INDEX = 4'd6,
        ST_COUNTED   = 4'd7,
        ST_CLEARED   = 4'd8
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_WAIT,
        S_CNT_RD,
        S_CNT_CHK,
        S_SORT_KEY_RD,
        S_SORT_KEY,
        S_SORT_CMP,
        S_SORT_PUT,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_DECIDE,
        S_DECIDE2,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INS_PUT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [31:0] hit_time;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [15:0] count;
        logic [31:0] energy;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] hit_time;
        logic [3:0]  hit_row;
        logic [3:0]  hit_col;
        logic [15:0] hit_count;
        logic [31:0] hit_energy;
        logic [6:0]  read_index;
    } t_in_beat;

    typedef struct packed {
        logic [3:0]  status;
        logic [7:0]  total_entries;
        logic [7:0]  anode_hits;
        logic [31:0] entry_time;
        logic [3:0]  entry_row;
        logic [3:0]  entry_col;
        logic [15:0] entry_count;
        logic [31:0] entry_energy;
    } t_out_beat;

endpackage

// ===== design/phmt_in_if.sv =====
// Input channel of the hit merge table: valid, ready and request beat.
// Depends on phmt_pkg.
`timescale 1ns / 1ps
interface phmt_in_if;
    logic                valid;
    logic                ready;
    phmt_pkg::t_in_beat  beat;

    modport source (output valid, output beat, input ready);
    modport sink (input valid, input beat, output ready);
endinterface

// ===== design/phmt_out_if.sv =====
// Result channel of the hit merge table: valid, ready and result beat.
// Depends on phmt_pkg.
`timescale 1ns / 1ps
interface phmt_out_if;
    logic                valid;
    logic                ready;
    phmt_pkg::t_out_beat beat;

    modport source (output valid, output beat, input ready);
    modport sink (input valid, input beat, output ready);
endinterface

// ===== design/phmt_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module phmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== design/phmt_merge_unit.sv =====
// Shared merge unit: window compare, anode match, saturating accumulate.
// Depends on phmt_pkg.
`timescale 1ns / 1ps
module phmt_merge_unit (
    input  phmt_pkg::t_rec i_base,
    input  phmt_pkg::t_rec i_hit,
    input  logic           i_later,
    input  logic [15:0]    i_window,
    output phmt_pkg::t_rec o_merged,
    output logic           o_match
);
    import phmt_pkg::*;

    logic [31:0] diff;
    logic [16:0] cnt_sum;
    logic [32:0] eng_sum;

    // later: base follows the hit in time, else base precedes it
    assign diff    = i_later ? (i_base.hit_time - i_hit.hit_time)
                             : (i_hit.hit_time - i_base.hit_time);
    assign o_match = (diff < {16'd0, i_window}) && (i_base.row == i_hit.row)
                     && (i_base.col == i_hit.col);

    assign cnt_sum = {1'b0, i_base.count} + {1'b0, i_hit.count};
    assign eng_sum = {1'b0, i_base.energy} + {1'b0, i_hit.energy};

    always_comb begin
        o_merged          = i_base;
        o_merged.hit_time = i_later ? i_hit.hit_time : i_base.hit_time;
        o_merged.count    = cnt_sum[16] ? 16'hFFFF : cnt_sum[15:0];
        o_merged.energy   = eng_sum[32] ? 32'hFFFF_FFFF : eng_sum[31:0];
    end
endmodule

// ===== design/photon_hit_merge_table.sv =====
// Photon hit merge table: top level with sequencer, table RAM and merge unit.
// Depends on phmt_pkg, phmt_in_if, phmt_out_if, phmt_ram, phmt_merge_unit.
// Sorted detect: search reads each earlier entry, shift moves each later entry
// up one slot, after a stable insertion sort that runs only after appends;
// the single RAM port pair walks the table. One request at a time.
// Reset (i_rst_n low, synchronous) empties the table; RAM contents are kept.
`timescale 1ns / 1ps
`include "photon_hit_merge_table_defines.svh"
module photon_hit_merge_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    phmt_in_if.sink                           i_in,
    phmt_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [phmt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [phmt_pkg::CFG_W-1:0]        i_cfg_data
);
    import phmt_pkg::*;

    t_state           r_state, n_state;
    t_rec             r_hit, n_hit, r_key, n_key, r_prev, n_prev;
    t_rec             r_succ, n_succ, r_entry, n_entry;
    logic             r_succ_v, n_succ_v;
    logic [CNT_W-1:0] r_total, n_total, r_i, n_i, r_j, n_j, r_cnt, n_cnt;
    logic             r_sorted, n_sorted;
    t_status          r_status, n_status;
    logic [7:0]       r_limit;
    logic [15:0]      r_window;
    logic             r_ov;
    t_out_beat        r_obeat;

    // RAM port
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    t_rec             ram_wdata, rd_rec;
    logic [REC_W-1:0] ram_rdata;

    // merge unit
    t_rec             mu_base, mu_merged;
    logic             mu_later, mu_match;

    // shared conditions
    logic             in_acc, slot_free, below_limit, full, idx_ok, sort_gt, early;
    logic             sort_last, pos_zero, skip_sort;
    logic [CNT_W-1:0] i_p1, i_m1, j_m1, j_m2;
    t_rec             hit_in;
    t_in_beat         beat;
    t_state           ins_state;

    assign beat   = i_in.beat;
    assign in_acc = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    assign hit_in = '{hit_time: beat.hit_time, row: beat.hit_row, col: beat.hit_col,
                      count: beat.hit_count, energy: beat.hit_energy};

    assign rd_rec      = t_rec'(ram_rdata);
    assign slot_free   = !r_ov || o_out.ready;
    assign below_limit = 32'(r_total) < 32'(r_limit);
    assign full        = r_total >= CNT_W'(CAPACITY);
    assign idx_ok      = 32'(beat.read_index) < 32'(r_total);
    assign skip_sort   = r_sorted || (r_total < CNT_W'(2));
    assign i_p1        = r_i + 1'b1;
    assign i_m1        = r_i - 1'b1;
    assign j_m1        = r_j - 1'b1;
    assign j_m2        = r_j - 2'd2;
    assign sort_gt     = rd_rec.hit_time > r_key.hit_time;
    assign early       = rd_rec.hit_time < r_hit.hit_time;
    assign sort_last   = (i_p1 == r_total);
    assign pos_zero    = (r_i == '0);

    // insertion: drop when full, otherwise open a gap at r_i unless r_i is the table end
    assign ins_state = full ? S_DONE : ((r_total == r_i) ? S_INS_PUT : S_SHIFT_RD);

    // one merge unit, predecessor in DECIDE, successor in DECIDE2
    assign mu_later = (r_state == S_DECIDE2);
    assign mu_base  = mu_later ? r_succ : r_prev;

    phmt_merge_unit u_merge (
        .i_base   (mu_base),
        .i_hit    (r_hit),
        .i_later  (mu_later),
        .i_window (r_window),
        .o_merged (mu_merged),
        .o_match  (mu_match)
    );

    phmt_ram #(.WIDTH(REC_W), .DEPTH(CAPACITY)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (t_func'(beat.func))
                        FN_CLEAR:  n_state = S_DONE;
                        FN_READ:   n_state = idx_ok ? S_RD_WAIT : S_DONE;
                        FN_COUNT:  n_state = (r_total == '0) ? S_DONE : S_CNT_RD;
                        FN_DETECT: begin
                            if (below_limit) n_state = S_DONE;
                            else if (skip_sort) n_state = S_SRCH_RD;
                            else n_state = S_SORT_KEY_RD;
                        end
                    endcase
                end
            end
            S_RD_WAIT:     n_state = S_DONE;
            S_CNT_RD:      n_state = S_CNT_CHK;
            S_CNT_CHK:     n_state = sort_last ? S_DONE : S_CNT_RD;
            S_SORT_KEY_RD: n_state = S_SORT_KEY;
            S_SORT_KEY:    n_state = S_SORT_CMP;
            S_SORT_CMP: begin
                if (sort_gt) n_state = (j_m1 == '0) ? S_SORT_PUT : S_SORT_CMP;
                else n_state = sort_last ? S_SRCH_RD : S_SORT_KEY_RD;
            end
            S_SORT_PUT:    n_state = sort_last ? S_SRCH_RD : S_SORT_KEY_RD;
            S_SRCH_RD:     n_state = (r_i == r_total) ? S_DECIDE : S_SRCH_CHK;
            S_SRCH_CHK:    n_state = early ? S_SRCH_RD : S_DECIDE;
            S_DECIDE: begin
                if (pos_zero) n_state = ins_state;
                else n_state = mu_match ? S_DONE : S_DECIDE2;
            end
            S_DECIDE2:     n_state = (r_succ_v && mu_match) ? S_DONE : ins_state;
            S_SHIFT_RD:    n_state = S_SHIFT_WR;
            S_SHIFT_WR:    n_state = (j_m1 == r_i) ? S_INS_PUT : S_SHIFT_RD;
            S_INS_PUT:     n_state = S_DONE;
            S_DONE:        n_state = slot_free ? S_IDLE : S_DONE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_hit     = r_hit;
        n_key     = r_key;
        n_prev    = r_prev;
        n_succ    = r_succ;
        n_succ_v  = r_succ_v;
        n_entry   = r_entry;
        n_total   = r_total;
        n_i       = r_i;
        n_j       = r_j;
        n_cnt     = r_cnt;
        n_sorted  = r_sorted;
        n_status  = r_status;
        ram_we    = 1'b0;
        ram_waddr = r_j[IDX_W-1:0];
        ram_wdata = r_hit;
        ram_raddr = r_i[IDX_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_hit    = hit_in;
                    n_cnt    = '0;
                    n_entry  = '0;
                    n_succ_v = 1'b0;
                    n_i      = '0;
                    unique case (t_func'(beat.func))
                        FN_CLEAR: begin
                            n_total  = '0;
                            n_sorted = 1'b0;
                            n_status = ST_CLEARED;
                        end
                        FN_READ: begin
                            ram_raddr = IDX_W'(beat.read_index);
                            n_status  = idx_ok ? ST_READ : ST_BAD_INDEX;
                        end
                        FN_COUNT: n_status = ST_COUNTED;
                        FN_DETECT: begin
                            if (below_limit) begin
                                if (full) begin
                                    n_status = ST_DROPPED;
                                end else begin
                                    ram_we    = 1'b1;
                                    ram_waddr = r_total[IDX_W-1:0];
                                    ram_wdata = hit_in;
                                    n_total   = r_total + 1'b1;
                                    n_sorted  = 1'b0;
                                    n_status  = ST_APPENDED;
                                end
                            end else if (skip_sort) begin
                                n_sorted = 1'b1;
                            end else begin
                                n_i = CNT_W'(1);
                            end
                        end
                    endcase
                end
            end
            S_RD_WAIT: n_entry = rd_rec;
            S_CNT_RD:  ram_raddr = r_i[IDX_W-1:0];
            S_CNT_CHK: begin
                if (rd_rec.row == r_hit.row && rd_rec.col == r_hit.col) begin
                    n_cnt = r_cnt + 1'b1;
                end
                n_i = i_p1;
            end
            S_SORT_KEY_RD: begin
                ram_raddr = r_i[IDX_W-1:0];
                n_j       = r_i;
            end
            S_SORT_KEY: begin
                n_key     = rd_rec;
                ram_raddr = j_m1[IDX_W-1:0];
            end
            S_SORT_CMP: begin
                ram_we    = 1'b1;
                ram_waddr = r_j[IDX_W-1:0];
                if (sort_gt) begin
                    // move the later entry up, look one further down
                    ram_wdata = rd_rec;
                    n_j       = j_m1;
                    ram_raddr = j_m2[IDX_W-1:0];
                end else begin
                    ram_wdata = r_key;
                    n_i       = sort_last ? '0 : i_p1;
                    n_sorted  = sort_last;
                end
            end
            S_SORT_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = r_key;
                n_i       = sort_last ? '0 : i_p1;
                n_sorted  = sort_last;
            end
            S_SRCH_RD: ram_raddr = r_i[IDX_W-1:0];
            S_SRCH_CHK: begin
                if (early) begin
                    n_prev = rd_rec;
                    n_i    = i_p1;
                end else begin
                    n_succ   = rd_rec;
                    n_succ_v = 1'b1;
                end
            end
            S_DECIDE: begin
                if (!pos_zero && mu_match) begin
                    ram_we    = 1'b1;
                    ram_waddr = i_m1[IDX_W-1:0];
                    ram_wdata = mu_merged;
                    n_status  = ST_MERGED_E;
                end else if (pos_zero) begin
                    if (full) n_status = ST_DROPPED;
                    n_j = r_total;
                end
            end
            S_DECIDE2: begin
                if (r_succ_v && mu_match) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_i[IDX_W-1:0];
                    ram_wdata = mu_merged;
                    n_status  = ST_MERGED_L;
                end else begin
                    if (full) n_status = ST_DROPPED;
                    n_j = r_total;
                end
            end
            S_SHIFT_RD: ram_raddr = j_m1[IDX_W-1:0];
            S_SHIFT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_j[IDX_W-1:0];
                ram_wdata = rd_rec;
                n_j       = j_m1;
            end
            S_INS_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = r_i[IDX_W-1:0];
                ram_wdata = r_hit;
                n_total   = r_total + 1'b1;
                n_status  = ST_INSERTED;
            end
            S_DONE: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_total  <= '0;
            r_sorted <= 1'b0;
            r_limit  <= LIMIT_RESET;
            r_window <= WINDOW_RESET;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_total  <= n_total;
            r_sorted <= n_sorted;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LIMIT:  r_limit  <= i_cfg_data[7:0];
                    CFG_WINDOW: r_window <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (r_state == S_DONE && slot_free) r_ov <= 1'b1;
            else if (o_out.ready) r_ov <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_hit    <= n_hit;
        r_key    <= n_key;
        r_prev   <= n_prev;
        r_succ   <= n_succ;
        r_succ_v <= n_succ_v;
        r_entry  <= n_entry;
        r_i      <= n_i;
        r_j      <= n_j;
        r_cnt    <= n_cnt;
        r_status <= n_status;
        if (r_state == S_DONE && slot_free) begin
            r_obeat.status        <= r_status;
            r_obeat.total_entries <= 8'(r_total);
            r_obeat.anode_hits    <= 8'(r_cnt);
            r_obeat.entry_time    <= r_entry.hit_time;
            r_obeat.entry_row     <= r_entry.row;
            r_obeat.entry_col     <= r_entry.col;
            r_obeat.entry_count   <= r_entry.count;
            r_obeat.entry_energy  <= r_entry.energy;
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.beat  = r_obeat;

    `PHMT_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, !i_in.ready, "ready after accept")
    `PHMT_ASSERT(a_total_bound, i_clk, i_rst_n, r_total <= CNT_W'(CAPACITY), "table overfilled")
    `PHMT_ASSERT_IMP(a_write_in_table, i_clk, i_rst_n, ram_we, 32'(ram_waddr) <= 32'(r_total), "write past table end")
    `PHMT_ASSERT_NXT(a_result_loaded, i_clk, i_rst_n, r_state == S_DONE && slot_free, o_out.valid, "result not loaded")
endmodule
